/* design/ara_pkg.sv */
// Package for the aligned range allocator.
// Holds the command and status codes; no dependencies.
package ara_pkg;

   typedef enum logic [1:0] {
      CMD_ALLOCATE = 2'd0,
      CMD_MARK     = 2'd1,
      CMD_RELEASE  = 2'd2,
      CMD_CONTAINS = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_UNAVAILABLE = 3'd1,
      ST_BAD_ALIGN   = 3'd2,
      ST_EXHAUSTED   = 3'd3,
      ST_OVERLAP     = 3'd4,
      ST_TABLE_FULL  = 3'd5
   } status_type;

   // Byte addresses of the configuration registers.
   localparam logic [3:0] REG_WINDOW_BASE = 4'd0;
   localparam logic [3:0] REG_WINDOW_END  = 4'd8;

endpackage

/* design/aligned_range_allocator_unit.sv */
// Top level of the aligned range allocator: sequencer, range table memory
// and configuration registers. Depends on ara_pkg.
//
// Channel   Direction  Handshake              Payload
// request   in         start && !busy         req_cmd, req_address, req_length, req_align
// response  out        rsp_valid, one cycle   rsp_status, rsp_granted_address, rsp_inside_res
// config    in/out     psel & penable & pwrite  paddr, pwdata, prdata (pready tied high)
//
// Contains, and any command refused before a table walk, answers in the cycle after the
// transfer. Allocate and mark used walk the range table through its single read port,
// with a read state and an evaluate state for each entry, and an insert moves each
// later entry up one place. Release scans the table once for a split and, without a
// split, once more to compact it; a split inserts the upper piece.
// Reset clears the range count and both window registers; the table memory is not
// cleared, since only entries below the count are ever read.
// The receiver cannot stall: each response is shown for exactly one cycle.
module aligned_range_allocator_unit #(
   parameter int MAX_RANGES = 64,
   parameter int ADDR_BITS  = 40
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_cmd,
   input  logic [ADDR_BITS-1:0]    req_address,
   input  logic [ADDR_BITS:0]      req_length,
   input  logic [ADDR_BITS-1:0]    req_align,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [ADDR_BITS-1:0]    rsp_granted_address,
   output logic                    rsp_inside_res,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [63:0]             pwdata,
   output logic [63:0]             prdata,
   output logic                    pready
);
   import ara_pkg::*;

   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int W  = ADDR_BITS + 3;

   typedef enum logic [3:0] {
      S_IDLE, S_AW_RD, S_AW_EV, S_AFIN, S_MW_RD, S_MW_EV, S_MFIN,
      S_RS_RD, S_RS_EV, S_RFIN, S_RSPL, S_RC_RD, S_RC_EV,
      S_IN_RD, S_IN_WR, S_IN_PUT
   } state_type;

   localparam logic [W-1:0]  LIM   = W'(1) << ADDR_BITS;
   localparam logic [CW-1:0] CMAX  = CW'(MAX_RANGES);

   state_type                state_ff;
   logic [ADDR_BITS-1:0]     base_ff;
   logic [ADDR_BITS:0]       wend_ff;
   logic [CW-1:0]            count_ff, idx_ff, pos_ff, ins_ff, n_ff, split_idx_ff;
   logic [W-1:0]             s_ff, e_ff, len_ff, am1_ff, cand_ff, prev_stop_ff;
   logic [W-1:0]             new_s_ff, new_e_ff, split_s_ff, split_e_ff;
   logic                     hit_ff, split_ff;
   logic [ADDR_BITS-1:0]     grant_ff;
   logic                     rsp_valid_ff, inside_ff;
   logic [2:0]               status_ff;
   logic [ADDR_BITS-1:0]     rsp_grant_ff;

   // Range table memory with a registered read port.
   logic [ADDR_BITS-1:0]     mem_start [MAX_RANGES];
   logic [ADDR_BITS:0]       mem_stop  [MAX_RANGES];
   logic [ADDR_BITS-1:0]     rd_start_ff;
   logic [ADDR_BITS:0]       rd_stop_ff;
   logic [IW-1:0]            rd_addr, wr_addr;
   logic                     wr_en;
   logic [W-1:0]             wr_start, wr_stop;

   logic [W-1:0] rs, re, base_w, end_w, end_cap, size_w, a_w, span_e;
   logic [W-1:0] up_stop, init_cand, cand_len;
   logic         rc_keep;
   logic [W-1:0] rc_s, rc_e;
   logic         pow2, inside_now;

   assign rs      = W'(rd_start_ff);
   assign re      = W'(rd_stop_ff);
   assign base_w  = W'(base_ff);
   assign end_w   = W'(wend_ff);
   assign end_cap = (end_w < LIM) ? end_w : LIM;
   assign a_w     = W'(req_align);
   assign span_e  = W'(req_address) + W'(req_length);
   assign pow2    = (a_w != '0) && ((a_w & (a_w - W'(1))) == '0);
   assign init_cand = (base_w + a_w - W'(1)) & ~(a_w - W'(1));
   assign up_stop   = (re + am1_ff) & ~am1_ff;
   assign cand_len  = cand_ff + len_ff;

   // Window containment test for the contains command.
   always_comb begin
      size_w = (end_w > base_w) ? end_w - base_w : '0;
      inside_now = (W'(req_address) >= base_w) && (W'(req_length) <= size_w) &&
                   ((W'(req_address) - base_w) <= (size_w - W'(req_length)));
   end

   // Compaction step of a release: what survives of the current entry.
   always_comb begin
      rc_keep = 1'b1;
      rc_s = rs;
      rc_e = re;
      if (re <= s_ff || rs >= e_ff) begin
         rc_keep = 1'b1;
      end else if (rs < s_ff) begin
         rc_e = s_ff;
      end else if (re > e_ff) begin
         rc_s = e_ff;
      end else begin
         rc_keep = 1'b0;
      end
   end

   // Memory port selection.
   always_comb begin
      rd_addr  = (state_ff == S_IN_RD) ? IW'(ins_ff - CW'(1)) : idx_ff[IW-1:0];
      wr_en    = 1'b0;
      wr_addr  = ins_ff[IW-1:0];
      wr_start = rs;
      wr_stop  = re;
      case (state_ff)
         S_IN_WR: begin
            wr_en = 1'b1;
         end
         S_IN_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IW-1:0];
            wr_start = new_s_ff;
            wr_stop  = new_e_ff;
         end
         S_RSPL: begin
            wr_en    = 1'b1;
            wr_addr  = split_idx_ff[IW-1:0];
            wr_start = split_s_ff;
            wr_stop  = s_ff;
         end
         S_RC_EV: begin
            wr_en    = rc_keep;
            wr_addr  = n_ff[IW-1:0];
            wr_start = rc_s;
            wr_stop  = rc_e;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr] <= wr_start[ADDR_BITS-1:0];
         mem_stop[wr_addr]  <= wr_stop[ADDR_BITS:0];
      end
      rd_start_ff <= mem_start[rd_addr];
      rd_stop_ff  <= mem_stop[rd_addr];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         wend_ff <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr == REG_WINDOW_BASE) base_ff <= pwdata[ADDR_BITS-1:0];
         if (paddr == REG_WINDOW_END)  wend_ff <= pwdata[ADDR_BITS:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == REG_WINDOW_BASE) prdata = 64'(base_ff);
      else if (paddr == REG_WINDOW_END) prdata = 64'(wend_ff);
   end

   assign pready = 1'b1;

   // Command sequencer and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  s_ff     <= W'(req_address);
                  len_ff   <= W'(req_length);
                  am1_ff   <= a_w - W'(1);
                  idx_ff   <= '0;
                  grant_ff <= '0;
                  status_ff    <= ST_OK;
                  inside_ff    <= 1'b0;
                  rsp_grant_ff <= '0;
                  case (cmd_type'(req_cmd))
                     CMD_ALLOCATE: begin
                        cand_ff <= init_cand;
                        if (base_ff == '0) begin
                           status_ff <= ST_UNAVAILABLE;
                           rsp_valid_ff <= 1'b1;
                        end else if (!pow2) begin
                           status_ff <= ST_BAD_ALIGN;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= S_AW_RD;
                        end
                     end
                     CMD_MARK: begin
                        e_ff <= span_e;
                        prev_stop_ff <= '0;
                        hit_ff <= 1'b0;
                        if (span_e > LIM) begin
                           status_ff <= ST_EXHAUSTED;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= S_MW_RD;
                        end
                     end
                     CMD_RELEASE: begin
                        e_ff <= (span_e > LIM) ? LIM : span_e;
                        split_ff <= 1'b0;
                        if (req_length == '0) rsp_valid_ff <= 1'b1;
                        else state_ff <= S_RS_RD;
                     end
                     default: begin
                        if (base_ff == '0) status_ff <= ST_UNAVAILABLE;
                        else inside_ff <= inside_now;
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            // Allocate: first-fit walk.
            S_AW_RD: begin
               state_ff <= (idx_ff == count_ff) ? S_AFIN : S_AW_EV;
            end
            S_AW_EV: begin
               if (cand_len <= rs) begin
                  state_ff <= S_AFIN;
               end else begin
                  if (up_stop > cand_ff) cand_ff <= up_stop;
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_AW_RD;
               end
            end
            S_AFIN: begin
               if (cand_ff > end_cap || len_ff > end_cap - cand_ff || cand_ff >= LIM) begin
                  status_ff <= ST_EXHAUSTED;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (len_ff == '0) begin
                  rsp_grant_ff <= cand_ff[ADDR_BITS-1:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (count_ff >= CMAX) begin
                  status_ff <= ST_TABLE_FULL;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  grant_ff <= cand_ff[ADDR_BITS-1:0];
                  new_s_ff <= cand_ff;
                  new_e_ff <= cand_len;
                  pos_ff   <= idx_ff;
                  ins_ff   <= count_ff;
                  state_ff <= S_IN_RD;
               end
            end
            // Mark used: find the insert point and test both neighbors.
            S_MW_RD: begin
               state_ff <= (idx_ff == count_ff) ? S_MFIN : S_MW_EV;
            end
            S_MW_EV: begin
               if (rs >= s_ff) begin
                  hit_ff   <= (rs < e_ff);
                  state_ff <= S_MFIN;
               end else begin
                  prev_stop_ff <= re;
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_MW_RD;
               end
            end
            S_MFIN: begin
               state_ff <= S_IDLE;
               if (hit_ff || prev_stop_ff > s_ff) begin
                  status_ff <= ST_OVERLAP;
                  rsp_valid_ff <= 1'b1;
               end else if (len_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
               end else if (count_ff >= CMAX) begin
                  status_ff <= ST_TABLE_FULL;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  new_s_ff <= s_ff;
                  new_e_ff <= e_ff;
                  pos_ff   <= idx_ff;
                  ins_ff   <= count_ff;
                  state_ff <= S_IN_RD;
               end
            end
            // Release: look for a range that must be split in two.
            S_RS_RD: begin
               state_ff <= (idx_ff == count_ff) ? S_RFIN : S_RS_EV;
            end
            S_RS_EV: begin
               if (rs < s_ff && re > e_ff) begin
                  split_ff     <= 1'b1;
                  split_idx_ff <= idx_ff;
                  split_s_ff   <= rs;
                  split_e_ff   <= re;
               end
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_RS_RD;
            end
            S_RFIN: begin
               idx_ff <= '0;
               n_ff   <= '0;
               if (!split_ff) begin
                  state_ff <= S_RC_RD;
               end else if (count_ff >= CMAX) begin
                  status_ff <= ST_TABLE_FULL;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_RSPL;
               end
            end
            S_RSPL: begin
               new_s_ff <= e_ff;
               new_e_ff <= split_e_ff;
               pos_ff   <= split_idx_ff + CW'(1);
               ins_ff   <= count_ff;
               state_ff <= S_IN_RD;
            end
            // Release without a split: compact the table in place.
            S_RC_RD: begin
               if (idx_ff == count_ff) begin
                  count_ff <= n_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_RC_EV;
               end
            end
            S_RC_EV: begin
               if (rc_keep) n_ff <= n_ff + CW'(1);
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_RC_RD;
            end
            // Insert: move entries up one place, then write the new range.
            S_IN_RD: begin
               state_ff <= (ins_ff == pos_ff) ? S_IN_PUT : S_IN_WR;
            end
            S_IN_WR: begin
               ins_ff   <= ins_ff - CW'(1);
               state_ff <= S_IN_RD;
            end
            S_IN_PUT: begin
               count_ff     <= count_ff + CW'(1);
               rsp_grant_ff <= grant_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_inside_res      = inside_ff;

endmodule

/* design/ara_checker.sv */
// Port-level checker for the aligned range allocator, with its bind.
// Depends on ara_pkg and aligned_range_allocator_unit.
module ara_checker #(
   parameter int ADDR_BITS = 40
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [2:0]           rsp_status,
   input logic [ADDR_BITS-1:0] rsp_granted_address,
   input logic                 rsp_inside_res
);
   import ara_pkg::*;

   // A grant is only ever given with a good status.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted_address != '0 |-> rsp_status == ST_OK)
      else $error("granted address with failing status");

   // A positive contains answer only comes with a good status.
   a_inside_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> rsp_status == ST_OK)
      else $error("inside result with failing status");

   // The end of a long command always delivers its response transfer.
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("command finished without response");

endmodule

bind aligned_range_allocator_unit ara_checker #(.ADDR_BITS(ADDR_BITS)) u_ara_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_granted_address(rsp_granted_address),
   .rsp_inside_res(rsp_inside_res)
);
